// ===== sv/vpw_pkg.sv =====
package vpw_pkg;

   // Field widths.
   localparam int TIME_WIDTH   = 16;
   localparam int KIND_WIDTH   = 2;
   localparam int NIBBLE_WIDTH = 4;
   localparam int COUNT_WIDTH  = 5;
   localparam int BITCNT_WIDTH = 2;
   localparam int CSR_IDX_WIDTH = 2;

   // Input opcodes.
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds.
   localparam logic [KIND_WIDTH-1:0] KIND_SOF    = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_NIBBLE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_EOF    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SHORT_MIN = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LONG_MIN  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SOF_MIN   = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EOF_MIN   = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [TIME_WIDTH-1:0] SHORT_MIN_RESET = 16'd6;
   localparam logic [TIME_WIDTH-1:0] LONG_MIN_RESET  = 16'd18;
   localparam logic [TIME_WIDTH-1:0] SOF_MIN_RESET   = 16'd30;
   localparam logic [TIME_WIDTH-1:0] EOF_MIN_RESET   = 16'd45;

   // Per-frame nibble cap.
   localparam logic [COUNT_WIDTH-1:0] MAX_NIBBLES = 5'd18;

   // Last bit position of a nibble.
   localparam logic [BITCNT_WIDTH-1:0] LAST_BIT = 2'd3;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] short_min_ticks;
      logic [TIME_WIDTH-1:0] long_min_ticks;
      logic [TIME_WIDTH-1:0] sof_min_ticks;
      logic [TIME_WIDTH-1:0] eof_min_ticks;
   } csr_regs_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]   symbol_kind;
      logic [NIBBLE_WIDTH-1:0] nibble_value;
   } rsp_item_type;

endpackage

// ===== sv/vpw_req_if.sv =====
interface vpw_req_if;
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic [vpw_pkg::TIME_WIDTH-1:0]  time_now;

   modport source (output valid, output opcode, output time_now, input ready);
   modport sink   (input valid, input opcode, input time_now, output ready);
endinterface

// ===== sv/vpw_rsp_if.sv =====
interface vpw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [vpw_pkg::KIND_WIDTH-1:0]    symbol_kind;
   logic [vpw_pkg::NIBBLE_WIDTH-1:0]  nibble_value;

   modport source (output valid, output symbol_kind, output nibble_value, input ready);
   modport sink   (input valid, input symbol_kind, input nibble_value, output ready);
endinterface

// ===== sv/vpw_bus_symbol_decoder_core.sv =====
// Channel  Direction  Payload                          Handshake
// req_chan in         opcode[0], time_now[15:0]        valid / ready
// rsp_chan out        symbol_kind[1:0], nibble_value[3:0] valid / ready
// csr      in         csr_index[1:0], csr_write_data[15:0] csr_write_enable
//
// One item per cycle unless the output stalls: an item is captured in the
// input register, decoded in the next cycle, and its result, if any, enters
// the output register as the stage advances. Reset is synchronous and
// clears all control state and the thresholds to their defaults. A stalled
// output holds back only an item with a result; other items pass freely.
module vpw_bus_symbol_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   vpw_req_if.sink                             req_chan,
   vpw_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [vpw_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [vpw_pkg::TIME_WIDTH-1:0]      csr_write_data
);

   vpw_pkg::csr_regs_type             regs;
   logic                              in_valid_ff;
   logic                              in_opcode_ff;
   logic [vpw_pkg::TIME_WIDTH-1:0]    in_time_ff;
   logic                              result_valid;
   vpw_pkg::rsp_item_type             result;
   logic                              advance;
   logic                              rsp_valid_ff;
   vpw_pkg::rsp_item_type             rsp_item_ff;

   vpw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .regs             (regs)
   );

   // The stage moves on unless its result finds the output register full.
   assign advance = in_valid_ff && (!result_valid || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   vpw_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .opcode       (in_opcode_ff),
      .time_now     (in_time_ff),
      .regs         (regs),
      .result_valid (result_valid),
      .result       (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_opcode_ff <= req_chan.opcode;
         in_time_ff   <= req_chan.time_now;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && result_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && result_valid) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.symbol_kind  = rsp_item_ff.symbol_kind;
   assign rsp_chan.nibble_value = rsp_item_ff.nibble_value;

endmodule

// ===== sv/vpw_csr.sv =====
module vpw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [vpw_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [vpw_pkg::TIME_WIDTH-1:0]      csr_write_data,
   output vpw_pkg::csr_regs_type               regs
);

   vpw_pkg::csr_regs_type regs_ff;
   vpw_pkg::csr_regs_type regs_in;

   // Decode the register index of a write.
   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            vpw_pkg::CSR_SHORT_MIN: regs_in.short_min_ticks = csr_write_data;
            vpw_pkg::CSR_LONG_MIN:  regs_in.long_min_ticks  = csr_write_data;
            vpw_pkg::CSR_SOF_MIN:   regs_in.sof_min_ticks   = csr_write_data;
            vpw_pkg::CSR_EOF_MIN:   regs_in.eof_min_ticks   = csr_write_data;
            default:                regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.short_min_ticks <= vpw_pkg::SHORT_MIN_RESET;
         regs_ff.long_min_ticks  <= vpw_pkg::LONG_MIN_RESET;
         regs_ff.sof_min_ticks   <= vpw_pkg::SOF_MIN_RESET;
         regs_ff.eof_min_ticks   <= vpw_pkg::EOF_MIN_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// ===== sv/vpw_decode.sv =====
module vpw_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            opcode,
   input  logic [vpw_pkg::TIME_WIDTH-1:0]  time_now,
   input  vpw_pkg::csr_regs_type           regs,
   output logic                            result_valid,
   output vpw_pkg::rsp_item_type           result
);

   logic [vpw_pkg::TIME_WIDTH-1:0]    last_edge_ff, last_edge_in;
   logic [vpw_pkg::TIME_WIDTH-1:0]    armed_time_ff, armed_time_in;
   logic                              level_ff, level_in;
   logic [vpw_pkg::NIBBLE_WIDTH-1:0]  shift_ff, shift_in;
   logic [vpw_pkg::BITCNT_WIDTH-1:0]  bit_count_ff, bit_count_in;
   logic [vpw_pkg::COUNT_WIDTH-1:0]   nibble_count_ff, nibble_count_in;
   logic                              armed_ff, armed_in;

   logic [vpw_pkg::TIME_WIDTH-1:0]    width;
   logic [vpw_pkg::TIME_WIDTH-1:0]    idle;
   logic                              width_ok;
   logic                              data_bit;
   logic [vpw_pkg::NIBBLE_WIDTH-1:0]  shift_next;

   // Pulse width and idle time, both with 16-bit wrap.
   assign width      = time_now - last_edge_ff;
   assign idle       = time_now - armed_time_ff;
   assign width_ok   = (width < regs.eof_min_ticks) && !(width < regs.short_min_ticks);
   assign data_bit   = (width < regs.long_min_ticks) ^ ~level_ff;
   assign shift_next = {shift_ff[vpw_pkg::NIBBLE_WIDTH-2:0], data_bit};

   // Next state and the result of the item in the stage.
   always_comb begin
      last_edge_in    = last_edge_ff;
      armed_time_in   = armed_time_ff;
      level_in        = level_ff;
      shift_in        = shift_ff;
      bit_count_in    = bit_count_ff;
      nibble_count_in = nibble_count_ff;
      armed_in        = armed_ff;
      result_valid    = 1'b0;
      result.symbol_kind  = vpw_pkg::KIND_EOF;
      result.nibble_value = '0;

      if (opcode == vpw_pkg::OP_TICK) begin
         // A tick ends the frame once the armed timeout has run out.
         if (armed_ff && !(idle < regs.eof_min_ticks)) begin
            shift_in        = '0;
            bit_count_in    = '0;
            nibble_count_in = '0;
            armed_in        = 1'b0;
            last_edge_in    = time_now;
            result_valid    = 1'b1;
            result.symbol_kind = vpw_pkg::KIND_EOF;
         end
      end else begin
         last_edge_in = time_now;
         level_in     = ~level_ff;
         if (width_ok) begin
            armed_in      = 1'b1;
            armed_time_in = time_now;
            if (level_ff && !(width < regs.sof_min_ticks)) begin
               // Long pulse ending at the low level: start of frame.
               shift_in        = '0;
               bit_count_in    = '0;
               nibble_count_in = '0;
               result_valid    = 1'b1;
               result.symbol_kind = vpw_pkg::KIND_SOF;
            end else if (bit_count_ff != vpw_pkg::LAST_BIT) begin
               shift_in     = shift_next;
               bit_count_in = bit_count_ff + 1'b1;
            end else begin
               // Fourth bit completes a nibble, sent only under the cap.
               shift_in     = '0;
               bit_count_in = '0;
               if (nibble_count_ff < vpw_pkg::MAX_NIBBLES) begin
                  nibble_count_in     = nibble_count_ff + 1'b1;
                  result_valid        = 1'b1;
                  result.symbol_kind  = vpw_pkg::KIND_NIBBLE;
                  result.nibble_value = shift_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff    <= '0;
         armed_time_ff   <= '0;
         level_ff        <= 1'b0;
         shift_ff        <= '0;
         bit_count_ff    <= '0;
         nibble_count_ff <= '0;
         armed_ff        <= 1'b0;
      end else if (step) begin
         last_edge_ff    <= last_edge_in;
         armed_time_ff   <= armed_time_in;
         level_ff        <= level_in;
         shift_ff        <= shift_in;
         bit_count_ff    <= bit_count_in;
         nibble_count_ff <= nibble_count_in;
         armed_ff        <= armed_in;
      end
   end

endmodule
